// ===== rtl/core/skl_pkg.sv =====
// Shared types and constants for the sorted key index lookup unit.
package skl_pkg;

  // Default sizing of the pair store.
  localparam int unsigned SKL_DEPTH    = 64;
  localparam int unsigned SKL_KEY_BITS = 14;

  // Fixed port widths of the transaction fields.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned IN_KEY_W = 14;
  localparam int unsigned POS_W    = 6;

  // Operation codes carried on the input channel.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_STEP,
    ST_TAIL,
    ST_PROBE,
    ST_CMP,
    ST_RESP
  } state_e;

  // One result transaction.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             table_full;
  } res_t;

endpackage

// ===== rtl/core/skl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module skl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/skl_seq.sv =====
// Sequencer that appends pairs, bubble-sorts the pair store and binary-searches it.
module skl_seq import skl_pkg::*; #(
  parameter int unsigned DEPTH    = SKL_DEPTH,
  parameter int unsigned KEY_BITS = SKL_KEY_BITS,
  localparam int unsigned IDX_W   = $clog2(DEPTH),
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1),
  localparam int unsigned PAIR_W  = KEY_BITS + IDX_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [IN_KEY_W-1:0] key_i,
  output logic                res_valid_o,
  input  logic                res_take_i,
  output res_t                res_o,
  output logic                mem_we_o,
  output logic [IDX_W-1:0]    mem_waddr_o,
  output logic [PAIR_W-1:0]   mem_wdata_o,
  output logic [IDX_W-1:0]    mem_raddr_o,
  input  logic [PAIR_W-1:0]   mem_rdata_i
);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                sorted_q, sorted_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [PAIR_W-1:0]   hold_q, hold_d;
  logic [IDX_W-1:0]    k_q, k_d;
  logic [IDX_W-1:0]    lim_q, lim_d;
  logic [CNT_W-1:0]    lo_q, lo_d;
  logic [CNT_W-1:0]    hip_q, hip_d;
  logic [IDX_W-1:0]    mid_q, mid_d;
  res_t                res_q, res_d;

  logic [KEY_BITS-1:0] key_m;
  logic [KEY_BITS-1:0] rd_key;
  logic [IDX_W-1:0]    rd_link;
  logic [KEY_BITS-1:0] hold_key;
  logic                full;
  logic                hold_gt;
  logic [IDX_W-1:0]    k_inc;
  logic [CNT_W:0]      mid_sum;
  logic [IDX_W-1:0]    mid;

  // Field extraction and the small datapath shared by sort and search.
  always_comb begin
    key_m    = KEY_BITS'(key_i);
    rd_key   = mem_rdata_i[PAIR_W-1:IDX_W];
    rd_link  = mem_rdata_i[IDX_W-1:0];
    hold_key = hold_q[PAIR_W-1:IDX_W];
    full     = (count_q == CNT_W'(DEPTH));
    hold_gt  = (hold_key > rd_key);
    k_inc    = k_q + 1'b1;
    mid_sum  = {1'b0, lo_q} + {1'b0, hip_q} - 1'b1;
    mid      = IDX_W'(mid_sum[CNT_W:1]);
  end

  // Next state and memory port control.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sorted_d    = sorted_q;
    key_d       = key_q;
    hold_d      = hold_q;
    k_d         = k_q;
    lim_d       = lim_q;
    lo_d        = lo_q;
    hip_d       = hip_q;
    mid_d       = mid_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = k_q;
    mem_wdata_o = hold_q;
    mem_raddr_o = '0;
    in_ready_o  = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_RESP);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d = key_m;
          res_d = '0;
          unique case (op_i)
            OP_CLEAR: begin
              count_d  = '0;
              sorted_d = 1'b1;
              state_d  = ST_RESP;
            end
            OP_APPEND: begin
              if (full) begin
                res_d.table_full = 1'b1;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = count_q[IDX_W-1:0];
                mem_wdata_o = {key_m, count_q[IDX_W-1:0]};
                count_d     = count_q + 1'b1;
                sorted_d    = 1'b0;
              end
              state_d = ST_RESP;
            end
            OP_LOOKUP: begin
              lo_d  = '0;
              hip_d = count_q;
              if (!sorted_q && (count_q >= CNT_W'(2))) begin
                // Start the first bubble pass by fetching entry zero.
                lim_d       = IDX_W'(count_q - 1'b1);
                mem_raddr_o = '0;
                state_d     = ST_HEAD;
              end else begin
                sorted_d = 1'b1;
                state_d  = ST_PROBE;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      // Entry zero arrives and becomes the carried pair of this pass.
      ST_HEAD: begin
        hold_d      = mem_rdata_i;
        k_d         = '0;
        mem_raddr_o = IDX_W'(1);
        state_d     = ST_STEP;
      end

      // The smaller of the carried pair and entry k+1 settles at entry k.
      // Only a strictly greater carried key moves on, so equal keys keep order.
      ST_STEP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = k_q;
        if (hold_gt) begin
          mem_wdata_o = mem_rdata_i;
        end else begin
          mem_wdata_o = hold_q;
          hold_d      = mem_rdata_i;
        end
        if (k_inc == lim_q) begin
          state_d = ST_TAIL;
        end else begin
          mem_raddr_o = k_inc + 1'b1;
          k_d         = k_inc;
          state_d     = ST_STEP;
        end
      end

      // The carried pair is the largest of the pass and lands at its end.
      ST_TAIL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = lim_q;
        mem_wdata_o = hold_q;
        if (lim_q == IDX_W'(1)) begin
          sorted_d = 1'b1;
          state_d  = ST_PROBE;
        end else begin
          lim_d       = lim_q - 1'b1;
          mem_raddr_o = '0;
          state_d     = ST_HEAD;
        end
      end

      // Issue the midpoint read, or give up once the window is empty.
      ST_PROBE: begin
        if (lo_q < hip_q) begin
          mid_d       = mid;
          mem_raddr_o = mid;
          state_d     = ST_CMP;
        end else begin
          state_d = ST_RESP;
        end
      end

      // Compare the probed key and narrow the window.
      ST_CMP: begin
        if (rd_key == key_q) begin
          res_d.found    = 1'b1;
          res_d.position = POS_W'(rd_link);
          state_d        = ST_RESP;
        end else if (key_q < rd_key) begin
          hip_d   = CNT_W'(mid_q);
          state_d = ST_PROBE;
        end else begin
          lo_d    = CNT_W'(mid_q) + 1'b1;
          state_d = ST_PROBE;
        end
      end

      ST_RESP: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      sorted_q <= 1'b1;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sorted_q <= sorted_d;
    end
  end

  // Working registers of the sort and the search.
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    hold_q <= hold_d;
    k_q    <= k_d;
    lim_q  <= lim_d;
    lo_q   <= lo_d;
    hip_q  <= hip_d;
    mid_q  <= mid_d;
    res_q  <= res_d;
  end

endmodule

// ===== rtl/core/sorted_key_index_lookup_unit.sv =====
// Top level of the sorted key index lookup unit: pair store, sequencer and output register.
//
// Usage: each input transaction carries op_i and key_i. A clear empties the
// index, an append stores the key with its arrival position, and a lookup
// returns found_o and position_o. Every transaction gives exactly one result.
// Both channels use valid/ready; a transaction moves when both are high.
//
// A lookup on a sorted index reads and then compares at each probe, and it
// needs at most ceil(log2(n+1)) probes. The first lookup after appends
// first bubble-sorts the n stored pairs through the single memory read
// port in n-1 passes. The block works on one transaction at a time.
//
// The output register holds a finished result while the receiver stalls,
// and the block still accepts the next transaction meanwhile. Reset empties
// the index; the memory itself is not cleared since only entries below the
// fill count are ever read.
module sorted_key_index_lookup_unit import skl_pkg::*; #(
  parameter int unsigned DEPTH    = SKL_DEPTH,
  parameter int unsigned KEY_BITS = SKL_KEY_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [IN_KEY_W-1:0] key_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o,
  output logic [POS_W-1:0]    position_o,
  output logic                table_full_o
);

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned PAIR_W = KEY_BITS + IDX_W;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [PAIR_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [PAIR_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_take;
  res_t              res;
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q, out_res_d;

  // Pair store: {key, arrival position} per entry.
  skl_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (DEPTH)
  ) u_skl_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  skl_seq #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_skl_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .key_i       (key_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Output register: takes a result when empty or being drained.
  always_comb begin
    res_take    = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_res_q.found;
  assign position_o   = out_res_q.position;
  assign table_full_o = out_res_q.table_full;

endmodule

// ===== rtl/core/skl_checker.sv =====
// Port-level checker for the sorted key index lookup unit and its bind.
module skl_checker import skl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [OP_W-1:0]     op_i,
  input logic [IN_KEY_W-1:0] key_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                found_o,
  input logic [POS_W-1:0]    position_o,
  input logic                table_full_o
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q, pend_d;

  // Count transactions accepted but not yet delivered.
  always_comb begin
    in_acc  = in_valid_i && in_ready_o;
    out_acc = out_valid_o && out_ready_i;
    pend_d  = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o)
      && $stable(position_o) && $stable(table_full_o))
    else $error("result changed while stalled");

  // No result without an accepted transaction behind it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without a pending transaction");

  // With one result waiting and one in flight, no further transaction enters.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !in_ready_o)
    else $error("input accepted with two transactions pending");

  // A hit never reports a dropped append.
  a_hit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> !table_full_o)
    else $error("hit flagged as table full");

  // A miss reports position zero.
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> position_o == '0)
    else $error("nonzero position without a hit");

endmodule

bind sorted_key_index_lookup_unit skl_checker u_skl_checker (.*);

// ===== verif/sorted_key_index_lookup_unit_tb.sv =====
// Self-checking testbench for the sorted key index lookup unit.
`timescale 1ns / 100ps

module sorted_key_index_lookup_unit_tb import skl_pkg::*; ();

  // The op field can carry a code the block does not define.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned TABLE_SLOTS  = SKL_DEPTH;
  localparam int unsigned KEY_MAX      = (1 << IN_KEY_W) - 1;
  localparam int unsigned TARGET_ITEMS = 850;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AT      = 200;
  localparam int unsigned PAUSE_AT     = 500;
  localparam int unsigned FILL_AT      = 250;
  localparam int unsigned SETTLE       = 64;
  // Watchdog limit, set well above the time a full-table sort takes.
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned REPORT_MAX   = 10;

  // Tracks the index contents and holds the answers still owed by the block.
  class key_index_scoreboard;
    logic [IN_KEY_W-1:0] keys[TABLE_SLOTS];
    logic [POS_W-1:0]    links[TABLE_SLOTS];
    int                  fill;
    bit                  in_order;
    res_t                owed_answers[$];
    int unsigned         mismatches;

    function new();
      fill       = 0;
      in_order   = 1'b1;
      mismatches = 0;
    endfunction

    // Apply one accepted transaction to the index and queue its answer.
    function void note_request(logic [OP_W-1:0] op, logic [IN_KEY_W-1:0] key);
      res_t                ans;
      logic [IN_KEY_W-1:0] tk;
      logic [POS_W-1:0]    tl;
      int                  lo;
      int                  hi;
      int                  mid;
      ans = '0;
      case (op)
        OP_CLEAR: begin
          fill     = 0;
          in_order = 1'b1;
        end
        OP_APPEND: begin
          if (fill < TABLE_SLOTS) begin
            keys[fill]  = key;
            links[fill] = POS_W'(fill);
            fill++;
            in_order = 1'b0;
          end else begin
            ans.table_full = 1'b1;
          end
        end
        OP_LOOKUP: begin
          // Bubble sort that swaps only on a strictly greater key, so equal
          // keys keep their arrival order.
          if (!in_order) begin
            for (int p = 0; p + 1 < fill; p++) begin
              for (int k = 0; k + 1 < fill - p; k++) begin
                if (keys[k] > keys[k+1]) begin
                  tk         = keys[k];
                  tl         = links[k];
                  keys[k]    = keys[k+1];
                  links[k]   = links[k+1];
                  keys[k+1]  = tk;
                  links[k+1] = tl;
                end
              end
            end
            in_order = 1'b1;
          end
          // Binary search with inclusive bounds; the first matching probe wins.
          lo = 0;
          hi = fill - 1;
          while (lo <= hi && !ans.found) begin
            mid = (lo + hi) / 2;
            if (key == keys[mid]) begin
              ans.found    = 1'b1;
              ans.position = links[mid];
            end else if (key < keys[mid]) begin
              hi = mid - 1;
            end else begin
              lo = mid + 1;
            end
          end
        end
        default: ;
      endcase
      owed_answers.push_back(ans);
    endfunction

    // Compare one accepted result with the oldest owed answer.
    function void check_result(logic found, logic [POS_W-1:0] position, logic full);
      res_t want;
      if (owed_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with no transaction pending: found=%0b position=%0d full=%0b",
                   $time, found, position, full);
        return;
      end
      want = owed_answers.pop_front();
      if (want.found !== found || want.position !== position || want.table_full !== full)
      begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: expected found=%0b pos=%0d full=%0b, got found=%0b pos=%0d full=%0b",
                   $time, want.found, want.position, want.table_full, found, position, full);
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     op_i        = '0;
  logic [IN_KEY_W-1:0] key_i       = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                found_o;
  logic [POS_W-1:0]    position_o;
  logic                table_full_o;

  key_index_scoreboard book = new();
  int unsigned         items_sent = 0;
  bit                  send_burst = 1'b0;

  sorted_key_index_lookup_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o),
    .position_o  (position_o),
    .table_full_o(table_full_o)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one transaction after a random gap and hold it until it is taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IN_KEY_W-1:0] key);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    key_i      <= key;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_request(op, key);
    items_sent++;
    if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
  endtask

  // Stop offering and wait until every owed answer has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (book.owed_answers.size() != 0) @(posedge clk_i);
  endtask

  // Main stimulus: reset, directed cases, then random sequences.
  initial begin
    logic [IN_KEY_W-1:0] k;
    logic [IN_KEY_W-1:0] pool[$];
    logic [OP_W-1:0]     noise_op;
    int unsigned         n_append;
    int unsigned         n_lookup;
    int unsigned         rounds;
    bit                  fill_up;
    bit                  filled_once;
    bit                  paused;
    filled_once = 1'b0;
    paused      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty index, unused code, and clear of an empty index.
    send_request(OP_LOOKUP, '0);
    send_request(OP_UNUSED, IN_KEY_W'(KEY_MAX));
    send_request(OP_CLEAR, '0);
    send_request(OP_LOOKUP, IN_KEY_W'(KEY_MAX));
    // Extreme and alternating keys, with duplicates.
    send_request(OP_APPEND, IN_KEY_W'(KEY_MAX));
    send_request(OP_APPEND, '0);
    send_request(OP_APPEND, 14'h2aaa);
    send_request(OP_APPEND, 14'h1555);
    send_request(OP_APPEND, '0);
    send_request(OP_APPEND, IN_KEY_W'(KEY_MAX));
    send_request(OP_LOOKUP, '0);
    send_request(OP_LOOKUP, IN_KEY_W'(KEY_MAX));
    send_request(OP_LOOKUP, 14'h2aaa);
    send_request(OP_LOOKUP, 14'h1555);
    // Misses on both sides of stored keys.
    send_request(OP_LOOKUP, 14'd7);
    send_request(OP_LOOKUP, IN_KEY_W'(KEY_MAX - 1));
    send_request(OP_UNUSED, '0);
    // An append after a lookup forces a second sort.
    send_request(OP_APPEND, 14'd100);
    send_request(OP_LOOKUP, 14'd100);
    send_request(OP_LOOKUP, '0);
    send_request(OP_CLEAR, IN_KEY_W'(KEY_MAX));
    send_request(OP_LOOKUP, '0);

    // Random part: mostly clear/append/lookup sequences, some noise.
    while (items_sent < TARGET_ITEMS) begin
      if (!paused && items_sent >= PAUSE_AT) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 10) begin
        noise_op = OP_W'($urandom_range(0, 3));
        k        = IN_KEY_W'($urandom_range(0, KEY_MAX));
        send_request(noise_op, k);
        if (noise_op == OP_CLEAR) pool.delete();
        else if (noise_op == OP_APPEND) pool.push_back(k);
      end else begin
        if ($urandom_range(0, 4) != 0) begin
          send_request(OP_CLEAR, IN_KEY_W'($urandom_range(0, KEY_MAX)));
          pool.delete();
        end
        fill_up = (!filled_once && items_sent >= FILL_AT) || $urandom_range(0, 59) == 0;
        if (fill_up) begin
          filled_once = 1'b1;
          n_append    = TABLE_SLOTS + 3;
        end else if ($urandom_range(0, 9) == 0) begin
          n_append = $urandom_range(13, 40);
        end else begin
          n_append = $urandom_range(1, 12);
        end
        rounds = $urandom_range(1, 2);
        repeat (rounds) begin
          repeat (n_append) begin
            if (pool.size() > 0 && $urandom_range(0, 3) == 0)
              k = pool[$urandom_range(0, pool.size() - 1)];
            else if ($urandom_range(0, 3) == 0)
              k = IN_KEY_W'($urandom_range(0, 15));
            else
              k = IN_KEY_W'($urandom_range(0, KEY_MAX));
            send_request(OP_APPEND, k);
            pool.push_back(k);
          end
          n_lookup = $urandom_range(1, 8);
          repeat (n_lookup) begin
            if (pool.size() > 0 && $urandom_range(0, 9) < 7)
              k = pool[$urandom_range(0, pool.size() - 1)];
            else
              k = IN_KEY_W'($urandom_range(0, KEY_MAX));
            send_request(OP_LOOKUP, k);
          end
          n_append = $urandom_range(1, 6);
        end
      end
    end

    // Let the last answers arrive and watch for strays.
    in_valid_i <= 1'b0;
    while (book.owed_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (book.mismatches == 0) begin
      $display("sorted_key_index_lookup_unit_tb: done, clean");
    end else begin
      $display("sorted_key_index_lookup_unit_tb: done, errors");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back the block up.
  initial begin
    int unsigned gap;
    int unsigned seen;
    bit          burst;
    seen  = 0;
    burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (seen == HOLD_AT) gap = LONG_HOLD;
      else gap = burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      book.check_result(found_o, position_o, table_full_o);
      seen++;
      if ($urandom_range(0, 39) == 0) burst = ~burst;
    end
  end

  // Watchdog: ends the run if no transaction moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("sorted_key_index_lookup_unit_tb: done, errors");
    $finish;
  end

endmodule
